[src/gplf_pkg.sv]
// Shared types, codes and arithmetic helpers for the Gaussian polar lagged
// Fibonacci generator. No dependencies; used by every module of the block.
`default_nettype none
package gplf_pkg;

    // Uniform width and output format
    localparam int FRAC_BITS     = 32;
    localparam int OUT_FRAC_BITS = 24;

    // Lagged Fibonacci table geometry
    localparam int         TAB_LEN   = 55;
    localparam int         TAB_AW    = 6;
    localparam logic [5:0] TAB_LAST  = 6'(TAB_LEN - 1);
    localparam logic [5:0] WP_RST    = 6'd54;
    localparam logic [5:0] LP_RST    = 6'd30;
    localparam logic [5:0] SP_RST    = 6'd53;

    // Refill congruential generator
    localparam logic [14:0] LCG_MUL  = 15'd2349;
    localparam logic [14:0] LCG_INC  = 15'd14867;
    localparam logic [15:0] LCG_MOD  = 16'd32767;
    // 2^32 = LCG_MOD * FRAC_SCALE + FRAC_REM
    localparam logic [31:0] FRAC_SCALE = 32'((64'd1 << 32) / 64'd32767);
    localparam logic [2:0]  FRAC_REM   = 3'((64'd1 << 32) % 64'd32767);

    // 2 ln 2 in Q.30
    localparam logic [30:0] LN2X2_Q30 = 31'd1488522236;

    // Rejection attempts before giving up, minus one
    localparam logic [5:0] ATT_LAST = 6'd63;

    // Datapath commands
    localparam logic [4:0] OP_NONE   = 5'd0;
    localparam logic [4:0] OP_LOAD   = 5'd1;
    localparam logic [4:0] OP_FILL   = 5'd2;
    localparam logic [4:0] OP_URD    = 5'd3;
    localparam logic [4:0] OP_UWR1   = 5'd4;
    localparam logic [4:0] OP_UWR2   = 5'd5;
    localparam logic [4:0] OP_SQ1    = 5'd6;
    localparam logic [4:0] OP_SQ2    = 5'd7;
    localparam logic [4:0] OP_CHK    = 5'd8;
    localparam logic [4:0] OP_DINIT  = 5'd9;
    localparam logic [4:0] OP_DIV    = 5'd10;
    localparam logic [4:0] OP_NORM   = 5'd11;
    localparam logic [4:0] OP_LOG    = 5'd12;
    localparam logic [4:0] OP_LMUL   = 5'd13;
    localparam logic [4:0] OP_LSUB   = 5'd14;
    localparam logic [4:0] OP_QL0    = 5'd15;
    localparam logic [4:0] OP_QL1    = 5'd16;
    localparam logic [4:0] OP_SQINIT = 5'd17;
    localparam logic [4:0] OP_SQRT   = 5'd18;
    localparam logic [4:0] OP_OUT    = 5'd19;
    localparam logic [4:0] OP_GIVEUP = 5'd20;

    typedef struct packed {
        logic [4:0] op;
        logic [5:0] idx;
    } t_cmd;

    typedef struct packed {
        logic s_ok;
        logic norm_done;
    } t_sts;

    // Step the refill generator: (x*2349 + 14867) mod 32767
    function automatic logic [14:0] lcg_next(input logic [14:0] x);
        logic [26:0] v;
        logic [15:0] red;
        v   = 27'(x) * 27'(LCG_MUL) + 27'(LCG_INC);
        // 2^15 is one more than the modulus: fold the high part down
        red = 16'(v[26:15]) + 16'(v[14:0]);
        if (red >= LCG_MOD) begin
            red = red - LCG_MOD;
        end
        return red[14:0];
    endfunction

    // floor(x * 2^32 / 32767) for x below 32767
    function automatic logic [31:0] to_frac(input logic [14:0] x);
        logic [31:0] base;
        logic [16:0] xr;
        logic [1:0]  f;
        base = 32'(x) * FRAC_SCALE;
        xr   = 17'(x) * 17'(FRAC_REM);
        if (xr >= 17'(3 * 32767)) begin
            f = 2'd3;
        end else if (xr >= 17'(2 * 32767)) begin
            f = 2'd2;
        end else if (xr >= 17'(32767)) begin
            f = 2'd1;
        end else begin
            f = 2'd0;
        end
        return base + 32'(f);
    endfunction

    // Advance a table index, wrapping at the table length
    function automatic logic [5:0] ptr_adv(input logic [5:0] p);
        return (p == TAB_LAST) ? 6'd0 : p + 6'd1;
    endfunction

endpackage
`default_nettype wire

[src/gplf_tab.sv]
// Uniform table: 55 x 32 memory, one write port, two registered read ports.
// Depends on gplf_pkg for the table geometry.
`default_nettype none
module gplf_tab (
    input  wire logic        i_clk,
    input  wire logic        i_we,
    input  wire logic [5:0]  i_waddr,
    input  wire logic [31:0] i_wdata,
    input  wire logic [5:0]  i_raddr_a,
    input  wire logic [5:0]  i_raddr_b,
    output logic      [31:0] o_rdata_a,
    output logic      [31:0] o_rdata_b
);

    logic [31:0] r_mem [gplf_pkg::TAB_LEN];

    // Write one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register both lag reads
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

[src/gplf_dp.sv]
// Datapath: refill generator, lag pointers, shared multiplier, divider,
// log, square root and output register. Depends on gplf_pkg and gplf_tab.
`default_nettype none
module gplf_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_seed_we,
    input  wire logic [14:0]     i_seed,
    input  wire gplf_pkg::t_cmd  i_cmd,
    output gplf_pkg::t_sts       o_sts,
    output logic      [31:0]     o_sample,
    output logic                 o_saturated
);

    localparam logic [32:0] ONE_F   = 33'h1_0000_0000;
    localparam logic [60:0] CEIL_ADD = 61'((64'd1 << 30) - 64'd1);

    logic [14:0] r_seed;
    logic [14:0] r_x;
    logic [5:0]  r_wp, r_lp, r_sp;
    logic [32:0] r_m1, r_m2;
    logic        r_neg;
    logic [64:0] r_sq1, r_sq2;
    logic [31:0] r_s, r_t;
    logic [32:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_w;
    logic [5:0]  r_k;
    logic [29:0] r_y;
    logic [60:0] r_yc;
    logic [35:0] r_l;
    logic [76:0] r_acc;
    logic [61:0] r_sw;
    logic [62:0] r_res, r_bit;
    logic [31:0] r_sample;
    logic        r_sat;

    logic [14:0] x_step;
    logic        tab_we;
    logic [5:0]  tab_waddr;
    logic [31:0] tab_wdata;
    logic [31:0] rd_a, rd_b;
    logic [31:0] u_sum;
    logic [32:0] u_dbl, u_mag;
    logic [32:0] ma, mb;
    logic [65:0] prod;
    logic [65:0] sum_sq;
    logic [33:0] s_full;
    logic [32:0] div_r2;
    logic        div_ge;
    logic [31:0] log_v;
    logic [36:0] kc;
    logic [30:0] yc_ceil;
    logic [62:0] sq_trial;
    logic        sq_ge;
    logic [31:0] mag;

    // Table write: refill entries or the new lagged sum
    assign x_step = gplf_pkg::lcg_next(r_x);
    always_comb begin
        tab_we    = 1'b0;
        tab_waddr = r_wp;
        tab_wdata = u_sum;
        case (i_cmd.op)
            gplf_pkg::OP_FILL: begin
                tab_we    = (i_cmd.idx != 6'd0);
                tab_waddr = i_cmd.idx - 6'd1;
                tab_wdata = gplf_pkg::to_frac(x_step);
            end
            gplf_pkg::OP_UWR1, gplf_pkg::OP_UWR2: begin
                tab_we = 1'b1;
            end
            default: begin
                tab_we = 1'b0;
            end
        endcase
    end

    gplf_tab u_tab (
        .i_clk     (i_clk),
        .i_we      (tab_we),
        .i_waddr   (tab_waddr),
        .i_wdata   (tab_wdata),
        .i_raddr_a (gplf_pkg::ptr_adv(r_lp)),
        .i_raddr_b (gplf_pkg::ptr_adv(r_sp)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // New uniform and its magnitude as 2u - 1
    assign u_sum = rd_a + rd_b;
    assign u_dbl = {u_sum, 1'b0};
    assign u_mag = u_sum[31] ? (u_dbl - ONE_F) : (ONE_F - u_dbl);

    // Shared multiplier operand selection
    always_comb begin
        ma = 33'd0;
        mb = 33'd0;
        case (i_cmd.op)
            gplf_pkg::OP_SQ1: begin
                ma = r_m1;
                mb = r_m1;
            end
            gplf_pkg::OP_SQ2: begin
                ma = r_m2;
                mb = r_m2;
            end
            gplf_pkg::OP_LOG: begin
                ma = 33'(r_w);
                mb = 33'(r_w);
            end
            gplf_pkg::OP_LMUL: begin
                ma = 33'(r_y);
                mb = 33'(gplf_pkg::LN2X2_Q30);
            end
            gplf_pkg::OP_QL0: begin
                ma = r_q;
                mb = 33'(r_l[17:0]);
            end
            gplf_pkg::OP_QL1: begin
                ma = r_q;
                mb = 33'(r_l[35:18]);
            end
            default: begin
                ma = 33'd0;
                mb = 33'd0;
            end
        endcase
    end
    assign prod = 66'(ma) * 66'(mb);

    // Acceptance test on s
    assign sum_sq = 66'(r_sq1) + 66'(r_sq2);
    assign s_full = sum_sq[65:32];
    assign o_sts.s_ok      = (s_full[33:32] == 2'b00);
    assign o_sts.norm_done = r_w[31] | r_w[30];

    // Step helpers
    assign div_r2   = {r_r, 1'b0};
    assign div_ge   = (div_r2 >= {1'b0, r_s});
    assign log_v    = prod[61:30];
    assign kc       = 37'(r_k) * 37'(gplf_pkg::LN2X2_Q30);
    assign yc_ceil  = 31'((r_yc + CEIL_ADD) >> 30);
    assign sq_trial = r_res + r_bit;
    assign sq_ge    = ({1'b0, r_sw} >= sq_trial);
    assign mag      = r_res[31:0];

    // Seed register and lag pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 15'd0;
            r_wp   <= gplf_pkg::WP_RST;
            r_lp   <= gplf_pkg::LP_RST;
            r_sp   <= gplf_pkg::SP_RST;
        end else begin
            if (i_seed_we) begin
                r_seed <= i_seed;
            end
            case (i_cmd.op)
                gplf_pkg::OP_LOAD: begin
                    r_wp <= gplf_pkg::WP_RST;
                    r_lp <= gplf_pkg::LP_RST;
                    r_sp <= gplf_pkg::SP_RST;
                end
                gplf_pkg::OP_URD: begin
                    r_wp <= gplf_pkg::ptr_adv(r_wp);
                    r_lp <= gplf_pkg::ptr_adv(r_lp);
                    r_sp <= gplf_pkg::ptr_adv(r_sp);
                end
                default: begin
                    r_wp <= r_wp;
                end
            endcase
        end
    end

    // Arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            gplf_pkg::OP_LOAD: begin
                r_x <= r_seed;
            end
            gplf_pkg::OP_FILL: begin
                r_x <= x_step;
            end
            gplf_pkg::OP_UWR1: begin
                r_m1  <= u_mag;
                r_neg <= ~u_sum[31];
            end
            gplf_pkg::OP_UWR2: begin
                r_m2 <= u_mag;
            end
            gplf_pkg::OP_SQ1: begin
                r_sq1 <= prod[64:0];
            end
            gplf_pkg::OP_SQ2: begin
                r_sq2 <= prod[64:0];
            end
            gplf_pkg::OP_CHK: begin
                // zero s is raised to one LSB
                r_s <= (s_full[31:0] == 32'd0) ? 32'd1 : s_full[31:0];
                r_t <= r_sq1[63:32];
            end
            gplf_pkg::OP_DINIT: begin
                r_q <= 33'(r_t >= r_s);
                r_r <= (r_t >= r_s) ? (r_t - r_s) : r_t;
                r_w <= r_s;
                r_k <= 6'd2;
                r_y <= 30'd0;
            end
            gplf_pkg::OP_DIV: begin
                if (div_ge) begin
                    r_r <= 32'(div_r2 - {1'b0, r_s});
                    r_q <= {r_q[31:0], 1'b1};
                end else begin
                    r_r <= div_r2[31:0];
                    r_q <= {r_q[31:0], 1'b0};
                end
            end
            gplf_pkg::OP_NORM: begin
                // bring s into [2^30, 2^31), tracking 32 - msb position
                if (r_w[31]) begin
                    r_w <= {1'b0, r_w[31:1]};
                    r_k <= 6'd1;
                end else if (!r_w[30]) begin
                    r_w <= {r_w[30:0], 1'b0};
                    r_k <= r_k + 6'd1;
                end
            end
            gplf_pkg::OP_LOG: begin
                if (log_v[31]) begin
                    r_w <= {1'b0, log_v[31:1]};
                    r_y <= {r_y[28:0], 1'b1};
                end else begin
                    r_w <= log_v;
                    r_y <= {r_y[28:0], 1'b0};
                end
            end
            gplf_pkg::OP_LMUL: begin
                r_yc <= prod[60:0];
            end
            gplf_pkg::OP_LSUB: begin
                r_l <= 36'(kc - 37'(yc_ceil));
            end
            gplf_pkg::OP_QL0: begin
                r_acc <= 77'(prod);
            end
            gplf_pkg::OP_QL1: begin
                r_acc <= r_acc + (77'(prod) << 18);
            end
            gplf_pkg::OP_SQINIT: begin
                r_sw  <= r_acc[75:14];
                r_res <= 63'd0;
                r_bit <= 63'd1 << 62;
            end
            gplf_pkg::OP_SQRT: begin
                if (sq_ge) begin
                    r_sw  <= 62'({1'b0, r_sw} - sq_trial);
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: begin
                r_x <= r_x;
            end
        endcase
    end

    // Output register: held until the beat is taken
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            gplf_pkg::OP_OUT: begin
                r_sat <= r_acc[76];
                if (r_acc[76]) begin
                    r_sample <= r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    r_sample <= r_neg ? (32'd0 - mag) : mag;
                end
            end
            gplf_pkg::OP_GIVEUP: begin
                r_sat    <= 1'b0;
                r_sample <= 32'd0;
            end
            default: begin
                r_sat <= r_sat;
            end
        endcase
    end

    assign o_sample    = r_sample;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

[src/gplf_ctrl.sv]
// Controller: sequences refill, rejection loop and the iterative units,
// and owns both handshakes. Depends on gplf_pkg.
`default_nettype none
module gplf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_seed_we,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_reseed,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire gplf_pkg::t_sts  i_sts,
    output gplf_pkg::t_cmd       o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FILL   = 5'd1;
    localparam logic [4:0] S_URD1   = 5'd2;
    localparam logic [4:0] S_UWR1   = 5'd3;
    localparam logic [4:0] S_URD2   = 5'd4;
    localparam logic [4:0] S_UWR2   = 5'd5;
    localparam logic [4:0] S_SQ1    = 5'd6;
    localparam logic [4:0] S_SQ2    = 5'd7;
    localparam logic [4:0] S_CHK    = 5'd8;
    localparam logic [4:0] S_GIVEUP = 5'd9;
    localparam logic [4:0] S_DINIT  = 5'd10;
    localparam logic [4:0] S_DIV    = 5'd11;
    localparam logic [4:0] S_NORM   = 5'd12;
    localparam logic [4:0] S_LOG    = 5'd13;
    localparam logic [4:0] S_LMUL   = 5'd14;
    localparam logic [4:0] S_LSUB   = 5'd15;
    localparam logic [4:0] S_QL0    = 5'd16;
    localparam logic [4:0] S_QL1    = 5'd17;
    localparam logic [4:0] S_SQINIT = 5'd18;
    localparam logic [4:0] S_SQRT   = 5'd19;
    localparam logic [4:0] S_OUT    = 5'd20;

    localparam logic [5:0] DIV_LAST  = 6'd31;
    localparam logic [5:0] LOG_LAST  = 6'd29;
    localparam logic [5:0] SQRT_LAST = 6'd31;

    logic [4:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [5:0] r_att, n_att;
    logic       r_needs_init, n_needs_init;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and command decode
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_att        = r_att;
        n_needs_init = r_needs_init | i_seed_we;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_in_ready   = 1'b0;
        o_cmd.op     = gplf_pkg::OP_NONE;
        o_cmd.idx    = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_att = 6'd0;
                    if (i_reseed || r_needs_init) begin
                        o_cmd.op = gplf_pkg::OP_LOAD;
                        n_cnt    = 6'd0;
                        n_state  = S_FILL;
                    end else begin
                        n_state = S_URD1;
                    end
                end
            end
            S_FILL: begin
                o_cmd.op = gplf_pkg::OP_FILL;
                if (r_cnt == 6'(gplf_pkg::TAB_LEN)) begin
                    n_needs_init = 1'b0;
                    n_state      = S_URD1;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_URD1: begin
                o_cmd.op = gplf_pkg::OP_URD;
                n_state  = S_UWR1;
            end
            S_UWR1: begin
                o_cmd.op = gplf_pkg::OP_UWR1;
                n_state  = S_URD2;
            end
            S_URD2: begin
                o_cmd.op = gplf_pkg::OP_URD;
                n_state  = S_UWR2;
            end
            S_UWR2: begin
                o_cmd.op = gplf_pkg::OP_UWR2;
                n_state  = S_SQ1;
            end
            S_SQ1: begin
                o_cmd.op = gplf_pkg::OP_SQ1;
                n_state  = S_SQ2;
            end
            S_SQ2: begin
                o_cmd.op = gplf_pkg::OP_SQ2;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.op = gplf_pkg::OP_CHK;
                if (i_sts.s_ok) begin
                    n_state = S_DINIT;
                end else if (r_att == gplf_pkg::ATT_LAST) begin
                    n_state = S_GIVEUP;
                end else begin
                    n_att   = r_att + 6'd1;
                    n_state = S_URD1;
                end
            end
            S_GIVEUP: begin
                if (out_free) begin
                    o_cmd.op    = gplf_pkg::OP_GIVEUP;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DINIT: begin
                o_cmd.op = gplf_pkg::OP_DINIT;
                n_cnt    = 6'd0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = gplf_pkg::OP_DIV;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_NORM;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_NORM: begin
                o_cmd.op = gplf_pkg::OP_NORM;
                if (i_sts.norm_done) begin
                    n_cnt   = 6'd0;
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                o_cmd.op = gplf_pkg::OP_LOG;
                if (r_cnt == LOG_LAST) begin
                    n_state = S_LMUL;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_LMUL: begin
                o_cmd.op = gplf_pkg::OP_LMUL;
                n_state  = S_LSUB;
            end
            S_LSUB: begin
                o_cmd.op = gplf_pkg::OP_LSUB;
                n_state  = S_QL0;
            end
            S_QL0: begin
                o_cmd.op = gplf_pkg::OP_QL0;
                n_state  = S_QL1;
            end
            S_QL1: begin
                o_cmd.op = gplf_pkg::OP_QL1;
                n_state  = S_SQINIT;
            end
            S_SQINIT: begin
                o_cmd.op = gplf_pkg::OP_SQINIT;
                n_cnt    = 6'd0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = gplf_pkg::OP_SQRT;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.op    = gplf_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= 6'd0;
            r_att        <= 6'd0;
            r_needs_init <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_att        <= n_att;
            r_needs_init <= n_needs_init;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

[src/gaussian_polar_lagged_fib_rng_unit.sv]
// Top level of the Gaussian polar lagged Fibonacci generator.
// Depends on gplf_pkg, gplf_ctrl and gplf_dp.
//
// Each request beat returns one unit-variance Gaussian sample in signed Q8.24.
// Uniforms come from a 55-entry additive lagged Fibonacci table; pairs are
// drawn until s < 1 (giving up with a zero sample after 64 rejections), and
// the result is r1 * sqrt(-2 ln s / s). A request passes through taking the
// beat, one or more rejection attempts (two table read/write steps and two
// passes through the shared multiplier and the check), the bit-serial
// divider, normalising s, 30 squaring rounds for the logarithm, scaling,
// the bit-serial square root and loading the output register. A refill of
// the table, taken on the first request after reset or a seed write and on
// any request with reseed set, comes first and writes one entry per cycle.
// The next request is taken while a finished sample still waits in the
// output register.
`default_nettype none
module gaussian_polar_lagged_fib_rng_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_reseed,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [31:0] o_sample,
    output logic             o_saturated,
    input  wire logic        i_seed_we,
    input  wire logic [14:0] i_seed
);

    gplf_pkg::t_cmd cmd;
    gplf_pkg::t_sts sts;

    gplf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_we   (i_seed_we),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_reseed    (i_reseed),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gplf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_we   (i_seed_we),
        .i_seed      (i_seed),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_sample    (o_sample),
        .o_saturated (o_saturated)
    );

endmodule
`default_nettype wire
